// ===== rtl/psma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psma_pkg
// Shared types, constants and helpers of the per-second speed minute averager.
// ----------------------------------------------------------------------------
package psma_pkg;

	// seconds per minute: slot count and divisor of the minute average
	localparam int SLOTS          = 60;
	localparam int SLOT_W         = 6;
	localparam int SPEED_W        = 8;
	localparam int STATUS_W       = 8;
	localparam int ENTRY_W        = SPEED_W + STATUS_W;
	localparam int SUM_W          = 14;
	localparam int HIST_DEPTH_DEF = 16;

	// time offsets of the two record kinds
	localparam logic [31:0] STOP_BACK = 32'd2;
	localparam logic [31:0] MIN_BACK  = 32'd50;

	// record kinds
	localparam logic KIND_STOP   = 1'b0;
	localparam logic KIND_MINUTE = 1'b1;

	// request bundle into the slot store
	typedef struct packed {
		logic                clr;
		logic                we;
		logic [SLOT_W-1:0]   waddr;
		logic [ENTRY_W-1:0]  wdata;
		logic                re;
		logic [SLOT_W-1:0]   raddr;
	} slot_req_t;

	// status of the divide-by-60 unit
	typedef struct packed {
		logic               busy;
		logic [SPEED_W-1:0] quot;
		logic [SLOT_W-1:0]  rem;
	} div_stat_t;

	// slot that precedes second s of the minute
	function automatic logic [SLOT_W-1:0] slot_before(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == '0) begin
			r = SLOT_W'(SLOTS - 1);
		end else begin
			r = s - 1'b1;
		end
		return r;
	endfunction

	// next slot, wrapping at the end of the minute
	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/psma_div60.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psma_div60
// Divide by 60: the dividend is latched on start and the result is registered
// on the next cycle. The remainder covers the full 32-bit dividend; the
// quotient byte is exact for dividends below 15360.
// ----------------------------------------------------------------------------
module psma_div60
	import psma_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	output div_stat_t   stat
);

	localparam logic [4:0]  MOD15   = 5'd15;
	// ceil(2^16 / 15): exact quotient by 15 for every 12-bit value
	localparam logic [12:0] RECIP15 = 13'd4370;

	logic                busy_q;
	logic [31:0]         num_q;
	logic [SLOT_W-1:0]   rem_q;
	logic [SPEED_W-1:0]  quot_q;
	logic [6:0]          nib_sum;
	logic [4:0]          fold;
	logic [3:0]          m15;
	logic [SLOT_W-1:0]   rem_nxt;
	logic [24:0]         prod;

	// n mod 60 = 4 * ((n >> 2) mod 15) + (n & 3); 16 == 1 mod 15 folds nibbles
	always_comb begin
		nib_sum = 7'(num_q[5:2]) + 7'(num_q[9:6]) + 7'(num_q[13:10])
			+ 7'(num_q[17:14]) + 7'(num_q[21:18]) + 7'(num_q[25:22])
			+ 7'(num_q[29:26]) + 7'(num_q[31:30]);
		fold    = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
		m15     = (fold >= MOD15) ? 4'(fold - MOD15) : fold[3:0];
		rem_nxt = {m15, num_q[1:0]};
	end

	// n / 60 = (n >> 2) / 15 by reciprocal multiplication
	assign prod = 25'(num_q[13:2]) * 25'(RECIP15);

	// busy for the one cycle between start and the registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			quot_q <= prod[23:16];
		end
	end

	assign stat.busy = busy_q;
	assign stat.quot = quot_q;
	assign stat.rem  = rem_q;

endmodule

// ===== rtl/psma_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psma_slot_ram
// Per-second speed/status store: one write and one registered read port.
// Valid flags give the all-zero reset and clear every slot at once.
// ----------------------------------------------------------------------------
module psma_slot_ram
	import psma_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  slot_req_t          req,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [SLOTS];
	logic [SLOTS-1:0]   vld_q;
	logic [ENTRY_W-1:0] rd_q;
	logic               rvld_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.we) begin
			vld_q[req.waddr] <= 1'b1;
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read; valid flag sampled with the data
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_q <= 1'b0;
		end else if (req.re) begin
			rvld_q <= vld_q[req.raddr];
		end
	end

	// slots never written since the last clear read as zero
	assign rd_data = rvld_q ? rd_q : '0;

endmodule

// ===== rtl/per_second_speed_minute_averager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_second_speed_minute_averager_core
// Per-second speed log with minute averaging and stop-time detection.
// ----------------------------------------------------------------------------
// One poll is handled at a time; in_ready is high only between polls, and a
// finished record waits in the output register without holding up the next
// poll. A plain one-second tick is decoded and then hands on its records, each
// of which may wait for the output register to free. The first valid poll and
// a clearing clock jump wait for the divide by 60 that finds the second of the
// minute; a forward gap while moving first copies the last stored slot forward,
// one slot per repeated second (up to 59). A tick that closes the minute sweeps
// the slot memory through its single read port, then divides the sum by 60 for
// the average. Slot clears act at once through per-slot valid flags, so there
// is no clearing pass after reset.
// ----------------------------------------------------------------------------
module per_second_speed_minute_averager_core
	import psma_pkg::*;
#(
	parameter int HISTORY_DEPTH = HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] time_count,
	input  logic        moving,
	input  logic [7:0]  speed,
	input  logic [7:0]  status,
	input  logic        sample_ready,
	input  logic        time_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] record_time,
	output logic [7:0]  minute_avg,
	output logic [5:0]  active_seconds,
	output logic [3:0]  ring_slot,
	output logic        last
);

	localparam int HIST_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_COPY = 3'd2;
	localparam logic [2:0] ST_FINJ = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_DIVS = 3'd5;
	localparam logic [2:0] ST_DIVW = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	// control state
	logic [2:0]          state_q;
	logic                started_q;
	logic                prev_mv_q;
	logic [31:0]         prev_q;
	logic [SLOT_W-1:0]   prev_mod_q;
	logic [SLOT_W-1:0]   wslot_q;
	logic [HIST_W-1:0]   hist_q;
	logic                stop_q;
	logic                rec_q;
	logic                out_valid_q;

	// latched poll and working registers
	logic [31:0]         t_q;
	logic                mv_q;
	logic [SPEED_W-1:0]  sp_q;
	logic [STATUS_W-1:0] st_q;
	logic                rdy_q;
	logic                tv_q;
	logic [SLOT_W-1:0]   cp_addr_q;
	logic [SLOT_W-1:0]   cp_cnt_q;
	logic [SLOT_W-1:0]   sw_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SLOT_W-1:0]   act_q;
	logic [SPEED_W-1:0]  avg_q;

	// output register
	logic                kind_q;
	logic [31:0]         rtime_q;
	logic [7:0]          avg_out_q;
	logic [5:0]          act_out_q;
	logic [3:0]          ring_q;
	logic                last_q;

	// decode and datapath wires
	logic                in_acc;
	logic                same;
	logic                jump;
	logic                clr_jump;
	logic                copy_jump;
	logic                tick;
	logic                smp;
	logic [31:0]         gap;
	logic                out_free;
	logic                ld_stop;
	logic                ld_rec;
	logic                div_done;
	logic [6:0]          ring_ext;
	logic [ENTRY_W-1:0]  rd_data;
	logic [SPEED_W-1:0]  rd_speed;
	slot_req_t           req;
	div_stat_t           dstat;
	logic                div_start;
	logic [31:0]         div_arg;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// classify the latched poll
	always_comb begin
		gap       = t_q - prev_q;
		same      = started_q && (t_q == prev_q);
		jump      = started_q && !same && (t_q != prev_q + 32'd1);
		clr_jump  = jump && ((t_q < prev_q) || !mv_q || (gap >= 32'(SLOTS)));
		copy_jump = jump && !clr_jump;
		tick      = started_q && !same && !jump;
		smp       = tick && tv_q && rdy_q;
	end

	// divide by 60: second of the minute, or the minute average
	assign div_start = ((state_q == ST_DEC) && ((!started_q && tv_q) || jump))
		|| (state_q == ST_DIVS);
	assign div_arg   = (state_q == ST_DIVS) ? 32'(sum_q) : t_q;
	assign div_done  = !dstat.busy;

	psma_div60 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_arg),
		.stat     (dstat)
	);

	// slot store requests
	always_comb begin
		req       = '0;
		req.clr   = ((state_q == ST_DEC) && ((!started_q && tv_q) || clr_jump))
			|| ((state_q == ST_DIVW) && div_done);
		req.we    = ((state_q == ST_DEC) && smp) || (state_q == ST_COPY);
		req.waddr = (state_q == ST_COPY) ? cp_addr_q : wslot_q;
		req.wdata = (state_q == ST_COPY) ? rd_data : {st_q, sp_q};
		req.re    = ((state_q == ST_DEC) && copy_jump)
			|| ((state_q == ST_SUM) && (sw_q != SLOT_W'(SLOTS)));
		req.raddr = (state_q == ST_SUM) ? sw_q : prev_mod_q;
	end

	psma_slot_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	assign rd_speed = rd_data[SPEED_W-1:0];

	// result hand-off into the output register
	assign out_free = !out_valid_q || out_ready;
	assign ld_stop  = (state_q == ST_EMIT) && stop_q && out_free;
	assign ld_rec   = (state_q == ST_EMIT) && !stop_q && rec_q && out_free;
	assign ring_ext = 7'(hist_q);

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= 1'b0;
			prev_mv_q   <= 1'b0;
			prev_q      <= '0;
			prev_mod_q  <= '0;
			wslot_q     <= '0;
			hist_q      <= '0;
			stop_q      <= 1'b0;
			rec_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (!started_q) begin
						state_q <= tv_q ? ST_FINJ : ST_IDLE;
					end else if (same) begin
						state_q <= ST_IDLE;
					end else if (copy_jump) begin
						state_q <= ST_COPY;
					end else if (clr_jump) begin
						state_q <= ST_FINJ;
					end else begin
						// normal tick
						stop_q    <= prev_mv_q && !mv_q;
						rec_q     <= 1'b0;
						prev_mv_q <= mv_q;
						if (smp) begin
							prev_q     <= t_q;
							// the counter wrapping to zero restarts the minute phase
							prev_mod_q <= (t_q == '0) ? '0 : slot_next(prev_mod_q);
							if (wslot_q == SLOT_W'(SLOTS - 1)) begin
								wslot_q <= '0;
								state_q <= ST_SUM;
							end else begin
								wslot_q <= wslot_q + 1'b1;
								state_q <= ST_EMIT;
							end
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_COPY: begin
					if (cp_cnt_q == SLOT_W'(1)) begin
						state_q <= ST_FINJ;
					end
				end
				ST_FINJ: begin
					if (div_done) begin
						prev_q     <= t_q;
						prev_mod_q <= dstat.rem;
						wslot_q    <= slot_before(dstat.rem);
						started_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SUM: begin
					if (sw_q == SLOT_W'(SLOTS)) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						rec_q   <= (act_q != '0);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (stop_q) begin
						if (out_free) begin
							stop_q <= 1'b0;
						end
					end else if (rec_q) begin
						if (out_free) begin
							rec_q <= 1'b0;
							if (hist_q == HIST_W'(HISTORY_DEPTH - 1)) begin
								hist_q <= '0;
							end else begin
								hist_q <= hist_q + 1'b1;
							end
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// poll capture, gap copy walk, minute sweep
	always_ff @(posedge clk) begin
		if (in_acc) begin
			t_q   <= time_count;
			mv_q  <= moving;
			sp_q  <= speed;
			st_q  <= status;
			rdy_q <= sample_ready;
			tv_q  <= time_valid;
		end
		if (state_q == ST_DEC) begin
			cp_addr_q <= slot_next(prev_mod_q);
			cp_cnt_q  <= gap[SLOT_W-1:0];
			sw_q      <= '0;
			sum_q     <= '0;
			act_q     <= '0;
		end
		if (state_q == ST_COPY) begin
			cp_addr_q <= slot_next(cp_addr_q);
			cp_cnt_q  <= cp_cnt_q - 1'b1;
		end
		if (state_q == ST_SUM) begin
			sw_q <= sw_q + 1'b1;
			// data of the previous read address arrives now
			if (sw_q != '0) begin
				sum_q <= sum_q + SUM_W'(rd_speed);
				act_q <= act_q + SLOT_W'(rd_speed != '0);
			end
		end
		if ((state_q == ST_DIVW) && div_done) begin
			avg_q <= dstat.quot;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_stop || ld_rec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_stop) begin
			kind_q    <= KIND_STOP;
			rtime_q   <= t_q - STOP_BACK;
			avg_out_q <= '0;
			act_out_q <= '0;
			ring_q    <= '0;
			last_q    <= !rec_q;
		end else if (ld_rec) begin
			kind_q    <= KIND_MINUTE;
			rtime_q   <= t_q - MIN_BACK;
			avg_out_q <= avg_q;
			act_out_q <= act_q;
			ring_q    <= ring_ext[3:0];
			last_q    <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign record_time    = rtime_q;
	assign minute_avg     = avg_out_q;
	assign active_seconds = act_out_q;
	assign ring_slot      = ring_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	// an accepted poll is decoded in the next cycle
	ap_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DEC)
		else $error("accepted poll not decoded");

	// write slot stays inside the minute
	ap_wslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		wslot_q < SLOT_W'(SLOTS) && prev_mod_q < SLOT_W'(SLOTS))
		else $error("slot pointer out of range");

	// once started, the block never falls back to the unstarted state
	ap_started: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |=> started_q)
		else $error("started flag dropped");

	// a stop event followed by a minute record is not the last result
	ap_stop_then_rec: assert property (@(posedge clk) disable iff (!arst_n)
		ld_stop && rec_q |=> out_valid_q && !last_q && kind_q == KIND_STOP)
		else $error("stop event wrongly marked last");
`endif

endmodule
